// ===== rtl/core/arfp_pkg.sv =====
// Shared types, codes and constants of the AT response frame parser.
`default_nettype none
package arfp_pkg;

    localparam logic [7:0] START_DELIM   = 8'h7E;
    localparam logic [7:0] LEN_REJECT    = 8'hFF;
    localparam logic [7:0] CSUM_BASE     = 8'hFF;

    localparam int         HEADER_BYTES  = 4;
    localparam int         DATA_OFFSET   = 8;
    localparam int         IDX_W         = 9;

    localparam logic [IDX_W-1:0] IDX_FID       = IDX_W'(HEADER_BYTES);
    localparam logic [IDX_W-1:0] IDX_CMD_HI    = IDX_W'(HEADER_BYTES + 1);
    localparam logic [IDX_W-1:0] IDX_CMD_LO    = IDX_W'(HEADER_BYTES + 2);
    localparam logic [IDX_W-1:0] IDX_DATA0     = IDX_W'(DATA_OFFSET);
    localparam logic [IDX_W-1:0] IDX_DATA1     = IDX_W'(DATA_OFFSET + 1);
    localparam logic [IDX_W-1:0] IDX_DATA2     = IDX_W'(DATA_OFFSET + 2);
    localparam logic [IDX_W-1:0] IDX_BODY_BASE = IDX_W'(HEADER_BYTES - 1);

    localparam logic [15:0] RST_CODE_OPEN   = 16'd21583;
    localparam logic [15:0] RST_CODE_START  = 16'd21076;
    localparam logic [15:0] RST_CODE_DONE   = 16'd21574;
    localparam logic [15:0] RST_CODE_RESULT = 16'd21586;

    typedef enum logic [1:0] {
        CFG_OPEN   = 2'd0,
        CFG_START  = 2'd1,
        CFG_DONE   = 2'd2,
        CFG_RESULT = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_LEN_HI = 3'd1,
        PH_LEN_LO = 3'd2,
        PH_BODY   = 3'd3,
        PH_SKIP   = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_LENGTH    = 2'd1,
        ERR_CHECKSUM  = 2'd2,
        ERR_EARLY_END = 2'd3
    } t_err;

    typedef enum logic [2:0] {
        KIND_OTHER  = 3'd0,
        KIND_OPEN   = 3'd1,
        KIND_START  = 3'd2,
        KIND_DONE   = 3'd3,
        KIND_RESULT = 3'd4
    } t_kind;

    typedef struct packed {
        logic       emit;
        t_err       err;
    } t_evt;

    typedef struct packed {
        logic [15:0] cmd;
        logic [7:0]  fid_byte;
        logic [7:0]  data0;
        logic [7:0]  data1;
        logic [7:0]  data2;
    } t_capture;

    typedef struct packed {
        logic [15:0] code_open;
        logic [15:0] code_start;
        logic [15:0] code_done;
        logic [15:0] code_result;
    } t_cfg;

    typedef struct packed {
        t_err        error_code;
        t_kind       reply_kind;
        logic [15:0] command_code;
        logic [7:0]  frame_number;
        logic [15:0] sent_count;
        logic [7:0]  signal_strength;
        logic [15:0] received_count;
        logic        wait_more;
    } t_result;

endpackage
`default_nettype wire

// ===== rtl/core/arfp_parser.sv =====
// Frame tracker: delimiter, length, checksum and field capture.
`default_nettype none
module arfp_parser
    import arfp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_fire,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_first,
    input  wire logic       i_last,
    output t_evt            o_evt,
    output t_capture        o_cap
);

    t_phase             r_phase, n_phase;
    logic [7:0]         r_len, n_len;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [7:0]         r_sum, n_sum;
    logic [7:0]         r_fid, n_fid;
    logic [15:0]        r_cmd, n_cmd;
    logic [7:0]         r_data [0:2];
    logic [7:0]         n_data [0:2];
    logic [IDX_W-1:0]   end_idx;

    assign end_idx = IDX_BODY_BASE + IDX_W'(r_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_len     <= '0;
            r_idx     <= '0;
            r_sum     <= '0;
            r_fid     <= '0;
            r_cmd     <= '0;
            r_data[0] <= '0;
            r_data[1] <= '0;
            r_data[2] <= '0;
        end else begin
            r_phase   <= n_phase;
            r_len     <= n_len;
            r_idx     <= n_idx;
            r_sum     <= n_sum;
            r_fid     <= n_fid;
            r_cmd     <= n_cmd;
            r_data[0] <= n_data[0];
            r_data[1] <= n_data[1];
            r_data[2] <= n_data[2];
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_len     = r_len;
        n_idx     = r_idx;
        n_sum     = r_sum;
        n_fid     = r_fid;
        n_cmd     = r_cmd;
        n_data[0] = r_data[0];
        n_data[1] = r_data[1];
        n_data[2] = r_data[2];
        o_evt     = '{emit: 1'b0, err: ERR_NONE};

        if (i_fire) begin
            if (i_first) begin
                // any buffer start abandons the current frame
                n_len     = '0;
                n_idx     = '0;
                n_sum     = '0;
                n_fid     = '0;
                n_cmd     = '0;
                n_data[0] = '0;
                n_data[1] = '0;
                n_data[2] = '0;
                if (i_byte != START_DELIM) begin
                    n_phase = PH_HUNT;
                end else begin
                    n_idx = IDX_W'(1);
                    if (i_last) begin
                        n_phase = PH_HUNT;
                        o_evt   = '{emit: 1'b1, err: ERR_EARLY_END};
                    end else begin
                        n_phase = PH_LEN_HI;
                    end
                end
            end else begin
                unique case (r_phase)
                    PH_LEN_HI: begin
                        n_len = i_byte;
                        n_idx = IDX_W'(2);
                        if (i_last) begin
                            n_phase = PH_HUNT;
                            o_evt   = '{emit: 1'b1, err: ERR_EARLY_END};
                        end else begin
                            n_phase = PH_LEN_LO;
                        end
                    end
                    PH_LEN_LO: begin
                        n_idx = IDX_W'(3);
                        if (r_len != 8'd0 || i_byte == LEN_REJECT) begin
                            n_len   = '0;
                            n_phase = i_last ? PH_HUNT : PH_SKIP;
                            o_evt   = '{emit: 1'b1, err: ERR_LENGTH};
                        end else begin
                            n_len = i_byte;
                            if (i_last) begin
                                n_phase = PH_HUNT;
                                o_evt   = '{emit: 1'b1, err: ERR_EARLY_END};
                            end else begin
                                n_phase = PH_BODY;
                            end
                        end
                    end
                    PH_BODY: begin
                        if (r_idx < end_idx) begin
                            n_sum = r_sum + i_byte;
                            n_idx = r_idx + IDX_W'(1);
                            if (r_idx == IDX_FID)    n_fid = i_byte;
                            if (r_idx == IDX_CMD_HI) n_cmd[15:8] = i_byte;
                            if (r_idx == IDX_CMD_LO) n_cmd[7:0]  = i_byte;
                            if (r_idx == IDX_DATA0)  n_data[0]   = i_byte;
                            if (r_idx == IDX_DATA1)  n_data[1]   = i_byte;
                            if (r_idx == IDX_DATA2)  n_data[2]   = i_byte;
                            if (i_last) begin
                                n_phase = PH_HUNT;
                                o_evt   = '{emit: 1'b1, err: ERR_EARLY_END};
                            end
                        end else begin
                            // checksum byte
                            n_phase = i_last ? PH_HUNT : PH_SKIP;
                            o_evt.emit = 1'b1;
                            o_evt.err  = ((CSUM_BASE - r_sum) == i_byte) ? ERR_NONE
                                                                         : ERR_CHECKSUM;
                        end
                    end
                    PH_SKIP: begin
                        if (i_last) n_phase = PH_HUNT;
                    end
                    default: begin
                        n_phase = PH_HUNT;
                    end
                endcase
            end
        end
    end

    assign o_cap = '{cmd: r_cmd, fid_byte: r_fid,
                     data0: r_data[0], data1: r_data[1], data2: r_data[2]};

endmodule
`default_nettype wire

// ===== rtl/core/arfp_classify.sv =====
// Command classification and result field assembly.
`default_nettype none
module arfp_classify
    import arfp_pkg::*;
(
    input  wire t_evt     i_evt,
    input  wire t_capture i_cap,
    input  wire t_cfg     i_cfg,
    output t_result       o_result
);

    t_kind kind;

    // first matching register wins
    always_comb begin
        priority if (i_cap.cmd == i_cfg.code_open)   kind = KIND_OPEN;
        else if     (i_cap.cmd == i_cfg.code_start)  kind = KIND_START;
        else if     (i_cap.cmd == i_cfg.code_done)   kind = KIND_DONE;
        else if     (i_cap.cmd == i_cfg.code_result) kind = KIND_RESULT;
        else                                         kind = KIND_OTHER;
    end

    always_comb begin
        o_result            = '0;
        o_result.error_code = i_evt.err;
        if (i_evt.err == ERR_NONE) begin
            o_result.reply_kind   = kind;
            o_result.command_code = i_cap.cmd;
            o_result.frame_number = i_cap.fid_byte;
            if (kind == KIND_START) begin
                o_result.sent_count = {i_cap.data0, i_cap.data1};
                o_result.wait_more  = 1'b1;
            end
            if (kind == KIND_RESULT) begin
                o_result.signal_strength = i_cap.data0;
                o_result.received_count  = {i_cap.data1, i_cap.data2};
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/arfp_out_reg.sv =====
// Result register with valid/ready hand-off.
`default_nettype none
module arfp_out_reg
    import arfp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_result,
    input  wire logic    i_take,
    output logic         o_valid,
    output logic         o_free,
    output t_result      o_result
);

    logic    r_valid, n_valid;
    t_result r_result;

    assign n_valid = i_load | (r_valid & ~i_take);
    assign o_free  = ~r_valid | i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
`default_nettype wire

// ===== rtl/core/at_response_frame_parser_unit.sv =====
// Top level of the AT response frame parser.
//
//  Channel   Direction  Handshake            Payload
//  --------  ---------  -------------------  ---------------------------------------
//  in        in         i_valid / o_ready    rx_byte, buffer_start, buffer_end
//  out       out        o_valid / i_ready    error, kind, command, frame, counts, rssi
//  cfg       in         i_cfg_we             i_cfg_idx, i_cfg_data (no read-back)
//
// One request per cycle sustained while results are taken. A request is latched in the
// input register; once the output register is free, the frame tracker and classifier
// settle combinationally and a result, if any, is written to the output register.
// Reset (synchronous, active low) puts the tracker in delimiter hunt, clears captures
// and loads the default command codes.
// A stalled output holds the input stage; o_ready stays high while the input register
// is empty or moving on, so the link runs at full rate whenever results are taken.
`default_nettype none
module at_response_frame_parser_unit
    import arfp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // input channel
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [7:0]        i_rx_byte,
    input  wire logic              i_buffer_start,
    input  wire logic              i_buffer_end,
    // result channel
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [1:0]             o_error_code,
    output logic [2:0]             o_reply_kind,
    output logic [15:0]            o_command_code,
    output logic [7:0]             o_frame_number,
    output logic [15:0]            o_sent_count,
    output logic signed [7:0]      o_signal_strength,
    output logic [15:0]            o_received_count,
    output logic                   o_wait_more,
    // configuration
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_idx,
    input  wire logic [15:0]       i_cfg_data
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_first;
    logic       r_in_last;

    t_cfg       r_cfg;
    t_evt       evt;
    t_capture   cap;
    t_result    result;
    t_result    out_result;
    logic       out_free;
    logic       fire;

    // the request in the input register moves on once the result slot can take it
    assign fire    = r_in_valid & out_free;
    assign o_ready = ~r_in_valid | fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte  <= i_rx_byte;
            r_in_first <= i_buffer_start;
            r_in_last  <= i_buffer_end;
        end
    end

    // command code registers; the user must write them only while idle, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.code_open   <= RST_CODE_OPEN;
            r_cfg.code_start  <= RST_CODE_START;
            r_cfg.code_done   <= RST_CODE_DONE;
            r_cfg.code_result <= RST_CODE_RESULT;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_OPEN:   r_cfg.code_open   <= i_cfg_data;
                CFG_START:  r_cfg.code_start  <= i_cfg_data;
                CFG_DONE:   r_cfg.code_done   <= i_cfg_data;
                CFG_RESULT: r_cfg.code_result <= i_cfg_data;
                default:    r_cfg             <= r_cfg;
            endcase
        end
    end

    arfp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_in_byte),
        .i_first (r_in_first),
        .i_last  (r_in_last),
        .o_evt   (evt),
        .o_cap   (cap)
    );

    arfp_classify u_classify (
        .i_evt    (evt),
        .i_cap    (cap),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    arfp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire & evt.emit),
        .i_result (result),
        .i_take   (i_ready),
        .o_valid  (o_valid),
        .o_free   (out_free),
        .o_result (out_result)
    );

    assign o_error_code      = out_result.error_code;
    assign o_reply_kind      = out_result.reply_kind;
    assign o_command_code    = out_result.command_code;
    assign o_frame_number    = out_result.frame_number;
    assign o_sent_count      = out_result.sent_count;
    assign o_signal_strength = $signed(out_result.signal_strength);
    assign o_received_count  = out_result.received_count;
    assign o_wait_more       = out_result.wait_more;

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench of the AT response frame parser: corner cases, then random frames.
`timescale 1ns / 100ps

module tb_top;
    import arfp_pkg::*;

    // Watchdog: far above the slowest correct run (every request waits out the longest
    // sender gap and the longest result stall, plus the block's accept-to-o_valid latency).
    localparam int CYCLE_LIMIT   = 400000;
    // Cycles to let pass once nothing is expected: covers the accept-to-o_valid latency
    // of a request that is still in flight but produces no reply.
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_LIMIT   = 5000;

    logic              i_clk;
    logic              i_rst_n        = 1'b0;
    logic              i_valid        = 1'b0;
    logic              o_ready;
    logic [7:0]        i_rx_byte      = '0;
    logic              i_buffer_start = 1'b0;
    logic              i_buffer_end   = 1'b0;
    logic              o_valid;
    logic              i_ready        = 1'b0;
    logic [1:0]        o_error_code;
    logic [2:0]        o_reply_kind;
    logic [15:0]       o_command_code;
    logic [7:0]        o_frame_number;
    logic [15:0]       o_sent_count;
    logic signed [7:0] o_signal_strength;
    logic [15:0]       o_received_count;
    logic              o_wait_more;
    logic              i_cfg_we       = 1'b0;
    logic [1:0]        i_cfg_idx      = '0;
    logic [15:0]       i_cfg_data     = '0;

    at_response_frame_parser_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_rx_byte         (i_rx_byte),
        .i_buffer_start    (i_buffer_start),
        .i_buffer_end      (i_buffer_end),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_error_code      (o_error_code),
        .o_reply_kind      (o_reply_kind),
        .o_command_code    (o_command_code),
        .o_frame_number    (o_frame_number),
        .o_sent_count      (o_sent_count),
        .o_signal_strength (o_signal_strength),
        .o_received_count  (o_received_count),
        .o_wait_more       (o_wait_more),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Deframer shadow: own copy of the tracker state and the command codes
    // ------------------------------------------------------------------
    t_phase            fr_phase = PH_HUNT;
    logic [7:0]        fr_len   = '0;
    logic [IDX_W-1:0]  fr_idx   = '0;
    logic [7:0]        fr_sum   = '0;
    logic [7:0]        fr_fid   = '0;
    logic [15:0]       fr_cmd   = '0;
    logic [2:0][7:0]   fr_data  = '0;
    logic              fr_used  = 1'b0;   // request reached the tracker (not ignored)
    t_cfg              fr_codes = '{RST_CODE_OPEN, RST_CODE_START, RST_CODE_DONE,
                                    RST_CODE_RESULT};

    t_result           pending_replies[$];
    logic [7:0]        tx_bytes[$];       // buffer under construction

    bit                quiet           = 1'b0;  // no idling on either side
    int                sink_hold       = 0;
    int                cycle_count     = 0;
    int                used_items      = 0;
    int                replies_checked = 0;
    int                mismatches      = 0;
    int                settings_used   = 1;

    // Advances the shadow by one received byte; returns 1 when a reply is due.
    function automatic bit deframe_byte(input logic [7:0] b, input logic first,
                                        input logic last, output t_result r);
        logic [IDX_W-1:0] end_idx;
        t_kind            kind;
        r       = '0;
        fr_used = (first && b == START_DELIM) ||
                  (!first && fr_phase inside {PH_LEN_HI, PH_LEN_LO, PH_BODY});
        // a marked first byte always abandons whatever was in progress
        if (first) begin
            fr_len  = '0;
            fr_idx  = '0;
            fr_sum  = '0;
            fr_fid  = '0;
            fr_cmd  = '0;
            fr_data = '0;
            if (b != START_DELIM) begin
                fr_phase = PH_HUNT;     // bad delimiter: dropped without a word
                return 1'b0;
            end
            fr_idx       = IDX_W'(1);
            fr_phase     = last ? PH_HUNT : PH_LEN_HI;
            r.error_code = ERR_EARLY_END;
            return last;
        end
        case (fr_phase)
            PH_LEN_HI: begin
                fr_len       = b;       // high length byte parked for one step
                fr_idx       = IDX_W'(2);
                fr_phase     = last ? PH_HUNT : PH_LEN_LO;
                r.error_code = ERR_EARLY_END;
                return last;
            end
            PH_LEN_LO: begin
                fr_idx = IDX_W'(3);
                // length of 255 or more wins over an end mark on the same byte
                if (fr_len != 8'd0 || b == LEN_REJECT) begin
                    fr_len       = '0;
                    fr_phase     = last ? PH_HUNT : PH_SKIP;
                    r.error_code = ERR_LENGTH;
                    return 1'b1;
                end
                fr_len       = b;
                fr_phase     = last ? PH_HUNT : PH_BODY;
                r.error_code = ERR_EARLY_END;
                return last;
            end
            PH_BODY: begin
                end_idx = IDX_BODY_BASE + IDX_W'(fr_len);
                if (fr_idx < end_idx) begin
                    fr_sum = fr_sum + b;
                    if (fr_idx == IDX_FID)
                        fr_fid = b;
                    else if (fr_idx == IDX_CMD_HI)
                        fr_cmd[15:8] = b;
                    else if (fr_idx == IDX_CMD_LO)
                        fr_cmd[7:0] = b;
                    else if (fr_idx >= IDX_DATA0 && fr_idx <= IDX_DATA2)
                        fr_data[fr_idx - IDX_DATA0] = b;
                    fr_idx       = fr_idx + 1'b1;
                    fr_phase     = last ? PH_HUNT : PH_BODY;
                    r.error_code = ERR_EARLY_END;
                    return last;
                end
                // checksum byte; anything after it up to the end mark is skipped
                fr_phase = last ? PH_HUNT : PH_SKIP;
                if (8'(CSUM_BASE - fr_sum) != b) begin
                    r.error_code = ERR_CHECKSUM;
                    return 1'b1;
                end
                // first matching register wins when codes are shared
                if (fr_cmd == fr_codes.code_open)
                    kind = KIND_OPEN;
                else if (fr_cmd == fr_codes.code_start)
                    kind = KIND_START;
                else if (fr_cmd == fr_codes.code_done)
                    kind = KIND_DONE;
                else if (fr_cmd == fr_codes.code_result)
                    kind = KIND_RESULT;
                else
                    kind = KIND_OTHER;
                r.reply_kind   = kind;
                r.command_code = fr_cmd;
                r.frame_number = fr_fid;
                if (kind == KIND_START) begin
                    r.sent_count = {fr_data[0], fr_data[1]};
                    r.wait_more  = 1'b1;
                end
                if (kind == KIND_RESULT) begin
                    r.signal_strength = fr_data[0];
                    r.received_count  = {fr_data[1], fr_data[2]};
                end
                return 1'b1;
            end
            PH_SKIP: begin
                if (last)
                    fr_phase = PH_HUNT;
                return 1'b0;
            end
            default: begin
                fr_phase = PH_HUNT;     // unmarked bytes while hunting
                return 1'b0;
            end
        endcase
    endfunction

    // Idle stretch: mostly short, now and then long.
    function automatic int idle_length();
        int k;
        k = $urandom_range(0, 99);
        if (k < 70)
            return $urandom_range(1, 3);
        else if (k < 95)
            return $urandom_range(4, 12);
        return $urandom_range(13, 40);
    endfunction

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Watchdog expired after %0d cycles", CYCLE_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result side: random back-pressure, one i_ready assignment per edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_sink
        if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            i_ready   <= 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < 15) begin
            sink_hold <= idle_length() - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    function automatic void check_field(input string name, input logic signed [31:0] want,
                                        input logic signed [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Every accepted reply is held against the oldest pending prediction.
    always @(posedge i_clk) begin : reply_checker
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_replies.size() == 0) begin
                $error("unexpected reply: error_code %0d, reply_kind %0d, command_code %0h",
                       o_error_code, o_reply_kind, o_command_code);
                mismatches++;
            end else begin
                want = pending_replies.pop_front();
                check_field("error_code", want.error_code, o_error_code);
                check_field("reply_kind", want.reply_kind, o_reply_kind);
                check_field("command_code", want.command_code, o_command_code);
                check_field("frame_number", want.frame_number, o_frame_number);
                check_field("sent_count", want.sent_count, o_sent_count);
                check_field("signal_strength", $signed(want.signal_strength),
                            o_signal_strength);
                check_field("received_count", want.received_count, o_received_count);
                check_field("wait_more", want.wait_more, o_wait_more);
                replies_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // Drives one request and returns at the edge that accepts it. Valid is only lowered
    // when a gap follows, so back-to-back requests never see a low/high pair in one step.
    task automatic send_request(input logic [7:0] b, input logic first, input logic last);
        int      gap;
        t_result r;
        gap = (quiet || $urandom_range(0, 1) == 0) ? 0 : idle_length();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_rx_byte      <= b;
        i_buffer_start <= first;
        i_buffer_end   <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (deframe_byte(b, first, last, r))
            pending_replies.push_back(r);
        if (fr_used)
            used_items++;
    endtask

    task automatic send_buffer(input bit mark_start, input bit mark_end);
        int n;
        n = tx_bytes.size();
        for (int i = 0; i < n; i++)
            send_request(tx_bytes[i], mark_start && i == 0, mark_end && i == n - 1);
    endtask

    // Holds off requests until every reply is in and the pipeline has gone quiet.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Loads all four command codes; only ever done with the block idle.
    task automatic program_codes(input logic [15:0] c_open, input logic [15:0] c_start,
                                 input logic [15:0] c_done, input logic [15:0] c_result);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_OPEN;
        i_cfg_data <= c_open;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_START;
        i_cfg_data <= c_start;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_DONE;
        i_cfg_data <= c_done;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_RESULT;
        i_cfg_data <= c_result;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        fr_codes = '{c_open, c_start, c_done, c_result};
        settings_used++;
    endtask

    // Body layout: api type, frame id, command hi/lo, status, data bytes, filler.
    task automatic build_frame(input logic [7:0] fid, input logic [15:0] cmd, input int blen,
                               input logic [23:0] data3, input bit bad_sum,
                               input int trailing);
        logic [7:0] b;
        logic [7:0] sum;
        tx_bytes.delete();
        tx_bytes.push_back(START_DELIM);
        tx_bytes.push_back(8'h00);
        tx_bytes.push_back(8'(blen));
        sum = '0;
        for (int i = 0; i < blen; i++) begin
            case (i)
                1:       b = fid;
                2:       b = cmd[15:8];
                3:       b = cmd[7:0];
                5:       b = data3[23:16];
                6:       b = data3[15:8];
                7:       b = data3[7:0];
                default: b = 8'($urandom);
            endcase
            sum = sum + b;
            tx_bytes.push_back(b);
        end
        b = CSUM_BASE - sum;
        if (bad_sum)
            b = b ^ 8'($urandom_range(1, 255));
        tx_bytes.push_back(b);
        repeat (trailing) tx_bytes.push_back(8'($urandom));
    endtask

    task automatic make_random_frame(input bit bad_sum, input int trailing);
        logic [7:0]  fid;
        logic [15:0] cmd;
        logic [23:0] data3;
        int          blen;
        int          k;
        k   = $urandom_range(0, 9);
        fid = (k == 0) ? 8'h00 : (k == 1) ? 8'hFF : 8'($urandom);
        // mostly one of the configured codes, some strangers and near misses
        k = $urandom_range(0, 9);
        case (k)
            0, 1:    cmd = fr_codes.code_open;
            2, 3:    cmd = fr_codes.code_start;
            4, 5:    cmd = fr_codes.code_done;
            6, 7:    cmd = fr_codes.code_result;
            8:       cmd = 16'($urandom);
            default: cmd = fr_codes.code_result ^ (16'd1 << $urandom_range(0, 15));
        endcase
        // short frames are frequent, long bodies rare
        k = $urandom_range(0, 99);
        if (k < 3)
            blen = $urandom_range(13, 254);
        else if (k < 20)
            blen = $urandom_range(0, 6);
        else
            blen = $urandom_range(7, 12);
        k = $urandom_range(0, 7);
        case (k)
            0:       data3 = 24'h000000;
            1:       data3 = 24'hFFFFFF;
            2:       data3 = {8'h80, 16'($urandom)};
            3:       data3 = {8'h7F, 16'($urandom)};
            default: data3 = 24'($urandom);
        endcase
        build_frame(fid, cmd, blen, data3, bad_sum, trailing);
    endtask

    // Mixed traffic: mostly well-formed frames, the rest broken buffers and noise.
    task automatic run_traffic(input int n_items);
        int         target;
        int         k;
        int         cut;
        logic [7:0] b;
        target = used_items + n_items;
        while (used_items < target) begin
            k = $urandom_range(0, 99);
            if (k < 60) begin
                make_random_frame(1'b0, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
                send_buffer(1'b1, 1'b1);
            end else if (k < 70) begin
                make_random_frame(1'b1, $urandom_range(0, 1));
                send_buffer(1'b1, 1'b1);
            end else if (k < 84) begin
                // cut before the checksum byte: ends early, or is abandoned by a new start
                make_random_frame(1'b0, 0);
                cut = $urandom_range(1, tx_bytes.size() - 1);
                while (tx_bytes.size() > cut) void'(tx_bytes.pop_back());
                send_buffer(1'b1, k < 78);
            end else if (k < 90) begin
                tx_bytes.delete();
                tx_bytes.push_back(START_DELIM);
                if ($urandom_range(0, 1)) begin
                    tx_bytes.push_back(8'($urandom_range(1, 255)));
                    tx_bytes.push_back(8'($urandom));
                end else begin
                    tx_bytes.push_back(8'h00);
                    tx_bytes.push_back(LEN_REJECT);
                end
                repeat ($urandom_range(0, 3)) tx_bytes.push_back(8'($urandom));
                send_buffer(1'b1, 1'b1);
            end else if (k < 95) begin
                do b = 8'($urandom); while (b == START_DELIM);
                tx_bytes.delete();
                tx_bytes.push_back(b);
                repeat ($urandom_range(0, 4)) tx_bytes.push_back(8'($urandom));
                send_buffer(1'b1, $urandom_range(0, 1));
            end else begin
                repeat ($urandom_range(1, 3))
                    send_request(8'($urandom), $urandom_range(0, 5) == 0,
                                 $urandom_range(0, 2) == 0);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Short directed buffers at the reset codes, one per special case.
    task automatic test_corner_cases();
        // unmarked byte while hunting, even with an end mark
        send_request(8'h00, 1'b0, 1'b1);
        // bad delimiter: the rest of that buffer is ignored, a stray 0x7E included
        send_request(8'h7F, 1'b1, 1'b0);
        send_request(START_DELIM, 1'b0, 1'b0);
        send_request(8'hFF, 1'b0, 1'b1);
        // lone delimiter that also ends the buffer
        send_request(START_DELIM, 1'b1, 1'b1);
        // abandoned mid-header by a new start, whose length byte is too large
        // on the very byte that ends the buffer
        tx_bytes = '{START_DELIM, 8'h00};
        send_buffer(1'b1, 1'b0);
        tx_bytes = '{START_DELIM, 8'h01, 8'h00};
        send_buffer(1'b1, 1'b1);
        // length of 255, rest of buffer skipped
        tx_bytes = '{START_DELIM, 8'h00, LEN_REJECT, 8'h55};
        send_buffer(1'b1, 1'b1);
        // empty body: nothing captured; trailing byte after the checksum
        tx_bytes = '{START_DELIM, 8'h00, 8'h00, CSUM_BASE, 8'h00};
        send_buffer(1'b1, 1'b1);
        // one body byte with a wrong checksum
        tx_bytes = '{START_DELIM, 8'h00, 8'h01, 8'h12, 8'h00};
        send_buffer(1'b1, 1'b1);
        // end mark inside the body and on the high length byte
        tx_bytes = '{START_DELIM, 8'h00, 8'h05, 8'h01};
        send_buffer(1'b1, 1'b1);
        tx_bytes = '{START_DELIM, 8'h00};
        send_buffer(1'b1, 1'b1);
    endtask

    task automatic test_default_codes();
        run_traffic(25);
        // pressure: hold the link until every reply has been taken
        wait_drained();
        quiet = 1'b1;
        run_traffic(25);
        quiet = 1'b0;
    endtask

    task automatic test_extreme_codes();
        program_codes(16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000);
        // longest legal body, start kind with the widest counts
        build_frame(8'hFF, 16'hFFFF, 254, 24'hFFFFFF, 1'b0, 0);
        send_buffer(1'b1, 1'b1);
        run_traffic(20);
        program_codes(16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF);
        run_traffic(20);
    endtask

    // Shared codes: the earlier register in open, start, done, result order wins.
    task automatic test_equal_codes();
        logic [15:0] a;
        logic [15:0] z;
        a = 16'($urandom);
        do z = 16'($urandom); while (z == a);
        program_codes(a, a, a, a);
        run_traffic(20);
        program_codes(z, a, a, z);
        run_traffic(20);
    endtask

    task automatic test_random_codes();
        repeat (3) begin
            program_codes(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            run_traffic(20);
        end
    endtask

    initial begin : main
        int waited;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_corner_cases();
        test_default_codes();
        test_extreme_codes();
        test_equal_codes();
        test_random_codes();

        // all requests are in: let the last replies come out, then settle
        i_valid <= 1'b0;
        waited = 0;
        while (pending_replies.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_replies.size() != 0) begin
            $error("%0d predicted replies never arrived", pending_replies.size());
            mismatches += pending_replies.size();
        end
        repeat (SETTLE_CYCLES * 4) @(posedge i_clk);

        $display("Summary: %0d frame bytes tracked, %0d replies compared field by field",
                 used_items, replies_checked);
        $display("Summary: %0d command code settings incl. extremes and shared codes",
                 settings_used);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/arfp_pkg.sv
rtl/core/arfp_parser.sv
rtl/core/arfp_classify.sv
rtl/core/arfp_out_reg.sv
rtl/core/at_response_frame_parser_unit.sv
dv/tb_top.sv
